[rtl/fqsr_pkg.sv]
// ----------------------------------------------------------------------------
// fqsr_pkg
// Shared types and constants for the searchable, reversible FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fqsr_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_FIND = 2'd2,
        FN_REV  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND,
        ST_RDF,
        ST_RDB,
        ST_CAPB,
        ST_OUT
    } state_t;

    typedef struct packed {
        func_t                     func;
        logic signed [DATA_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [3:0]                found_index;
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  back_value;
        logic [4:0]                occupancy;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/fqsr_store.sv]
// ----------------------------------------------------------------------------
// fqsr_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fqsr_store #(
    parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [fqsr_pkg::DATA_W-1:0]    wr_data,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic      [fqsr_pkg::DATA_W-1:0]    rd_data
);
    import fqsr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/fqsr_seq.sv]
// ----------------------------------------------------------------------------
// fqsr_seq
// Sequencer: queue pointers, shared slot address unit, compare unit and the
// read steps for search, front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fqsr_seq #(
    parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire fqsr_pkg::req_t                 req,
    output logic                                ready,
    output logic                                done_valid,
    output fqsr_pkg::rsp_t                      done,
    input  wire logic                           done_take,
    output logic                                wr_en,
    output logic      [AW-1:0]                  wr_addr,
    output logic      [fqsr_pkg::DATA_W-1:0]    wr_data,
    output logic      [AW-1:0]                  rd_addr,
    input  wire logic [fqsr_pkg::DATA_W-1:0]    rd_data
);
    import fqsr_pkg::*;

    localparam logic [CW-1:0] FULL_C   = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      rev_reg, rev_next;
    func_t                     func_reg, func_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    status_t                   status_reg, status_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]             cmp_pos_reg, cmp_pos_next;
    logic [CW-1:0]             found_reg, found_next;
    logic [DATA_W-1:0]         front_reg, front_next;
    logic [DATA_W-1:0]         back_reg, back_next;

    logic [CW-1:0]             pos_sel;
    logic [CW-1:0]             off_full;
    logic [AW:0]               slot_sum;
    logic [AW:0]               slot_wrap;
    logic [AW-1:0]             slot_addr;
    logic [AW-1:0]             head_dec;
    logic [AW-1:0]             head_inc;
    logic                      match;
    logic [CW+4:0]             occ_ext;
    logic [CW+3:0]             found_ext;

    // shared slot address unit
    always_comb
    begin
        pos_sel = idx_reg;
        case (state_reg)
            ST_EXEC: pos_sel = count_reg;
            ST_FIND: pos_sel = idx_reg;
            ST_RDF:  pos_sel = '0;
            ST_RDB:  pos_sel = count_reg - CW'(1);
            default: pos_sel = idx_reg;
        endcase
        if (rev_reg && (state_reg != ST_EXEC))
        begin
            off_full = count_reg - CW'(1) - pos_sel;
        end
        else
        begin
            off_full = pos_sel;
        end
        slot_sum  = {1'b0, head_reg} + {1'b0, off_full[AW-1:0]};
        slot_wrap = (slot_sum >= DEPTH_W) ? (slot_sum - DEPTH_W) : slot_sum;
        slot_addr = slot_wrap[AW-1:0];
    end

    assign head_dec = (head_reg == '0) ? LAST_IDX : (head_reg - AW'(1));
    assign head_inc = (head_reg == LAST_IDX) ? '0 : (head_reg + AW'(1));
    assign match    = cmp_valid_reg && (rd_data == value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        cmp_pos_reg <= cmp_pos_next;
        found_reg   <= found_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (func_reg == FN_FIND) ? ST_FIND : ST_RDF;
            end
            ST_FIND:
            begin
                if (match || (idx_reg == count_reg))
                begin
                    state_next = ST_RDF;
                end
            end
            ST_RDF:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_CAPB;
            ST_CAPB: state_next = ST_OUT;
            ST_OUT:
            begin
                if (done_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_pos_next   = cmp_pos_reg;
        found_next     = found_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_addr;
        wr_data        = value_reg;
        rd_addr        = slot_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = req.func;
                    value_next = req.value;
                end
            end
            ST_EXEC:
            begin
                status_next    = STS_OK;
                found_next     = '0;
                idx_next       = '0;
                cmp_valid_next = 1'b0;
                case (func_reg)
                    FN_ENQ:
                    begin
                        if (count_reg == FULL_C)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (rev_reg)
                            begin
                                wr_addr   = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end
                    FN_DEQ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (!rev_reg)
                            begin
                                head_next = head_inc;
                            end
                        end
                    end
                    FN_FIND:
                    begin
                        status_next = STS_NOTFOUND;
                    end
                    FN_REV:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else if (count_reg != CW'(1))
                        begin
                            rev_next = !rev_reg;
                        end
                    end
                    default: status_next = STS_OK;
                endcase
            end
            ST_FIND:
            begin
                if (match)
                begin
                    status_next = STS_OK;
                    found_next  = cmp_pos_reg;
                end
                else if (idx_reg != count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = idx_reg;
                    idx_next       = idx_reg + CW'(1);
                end
            end
            ST_RDB:
            begin
                front_next = (count_reg == '0) ? '0 : rd_data;
            end
            ST_CAPB:
            begin
                back_next = (count_reg == '0) ? '0 : rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign occ_ext   = {5'b0, count_reg};
    assign found_ext = {4'b0, found_reg};

    assign ready             = (state_reg == ST_IDLE);
    assign done_valid        = (state_reg == ST_OUT);
    assign done.status       = status_reg;
    assign done.found_index  = found_ext[3:0];
    assign done.front_value  = front_reg;
    assign done.back_value   = back_reg;
    assign done.occupancy    = occ_ext[4:0];

endmodule

`default_nettype wire

[rtl/fifo_queue_with_search_reverse.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse
// Bounded FIFO of signed 32-bit values with search and order reversal.
// ----------------------------------------------------------------------------
// Takes one request at a time and gives one response per request. Enqueue,
// dequeue and reverse pass the execute, front read, back read, back capture
// and output states; a find adds a search state, walking the entries one
// per cycle. These steps come from the single read port of the entry store,
// which also serves the front and back reads of every response. The
// response sits in an output register, so the queue accepts the next
// request while that response waits. Reverse flips a direction flag only.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search_reverse #(
    parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire fqsr_pkg::req_t     req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output fqsr_pkg::rsp_t          rsp
);
    import fqsr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              ready;
    logic              start;
    logic              done_valid;
    rsp_t              done;
    logic              done_take;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    assign req_stall = !ready;
    assign start     = req_valid && ready;
    assign done_take = !rsp_valid_reg || !rsp_stall;

    fqsr_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .ready      (ready),
        .done_valid (done_valid),
        .done       (done),
        .done_take  (done_take),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    fqsr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (done_valid && done_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
